// File: hdl/edfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_pkg
// shared types, constants and helpers of the edf periodic task scheduler
// ----------------------------------------------------------------------------
package edfs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic        command;
        logic [3:0]  task_index;
        logic [15:0] exec_time;
        logic [31:0] first_deadline;
        logic [31:0] first_release;
        logic [15:0] period;
    } item_t;

    typedef struct packed {
        logic        ran_valid;
        logic [3:0]  ran_task;
        logic [15:0] remaining_after;
        logic        job_done;
        logic [31:0] current_time;
        logic [31:0] busy_units;
        logic [47:0] waiting_sum;
        logic [47:0] turnaround_sum;
    } result_t;

    // best task so far, handed from cell to cell
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [31:0]      deadline;
        logic [31:0]      release_time;
        logic [15:0]      remaining;
        logic [15:0]      exec;
    } cand_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_DEC,
        OP_DONE
    } cell_op_t;

    // update broadcast to every cell, taken by the addressed one
    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
        logic [15:0]      exec;
        logic [31:0]      deadline;
        logic [31:0]      release_time;
        logic [15:0]      period;
    } cell_cmd_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: hdl/edfs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfs_cell
// one task slot of the scan chain: holds the task and keeps the earlier deadline
// ----------------------------------------------------------------------------
module edfs_cell
    import edfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] slot,
    input  logic             active,
    input  logic [31:0]      time_now,
    input  cell_cmd_t        cmd,
    input  cand_t            cand_in,
    output cand_t            cand_out
);

    logic [15:0] exec_reg, exec_next;
    logic [15:0] period_reg, period_next;
    logic [31:0] release_reg, release_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [15:0] remaining_reg, remaining_next;
    cand_t       cand_reg, cand_next;

    logic hit;
    logic eligible;
    logic take;

    always_comb
    begin
        hit            = (cmd.idx == slot);
        exec_next      = exec_reg;
        period_next    = period_reg;
        release_next   = release_reg;
        deadline_next  = deadline_reg;
        remaining_next = remaining_reg;
        if (hit)
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    exec_next      = cmd.exec;
                    period_next    = cmd.period;
                    release_next   = cmd.release_time;
                    deadline_next  = cmd.deadline;
                    remaining_next = cmd.exec;
                end
                OP_DEC:
                begin
                    remaining_next = remaining_reg - 16'd1;
                end
                OP_DONE:
                begin
                    release_next   = sat_add32(release_reg, {16'd0, period_reg});
                    deadline_next  = sat_add32(deadline_reg, {16'd0, period_reg});
                    remaining_next = exec_reg;
                end
                default:
                begin
                end
            endcase
        end

        // strict compare keeps the lower index on equal deadlines
        eligible = active && (release_reg <= time_now) && (remaining_reg != 16'd0);
        take     = eligible && (!cand_in.found || (deadline_reg < cand_in.deadline));
        if (take)
        begin
            cand_next.found        = 1'b1;
            cand_next.idx          = slot;
            cand_next.deadline     = deadline_reg;
            cand_next.release_time = release_reg;
            cand_next.remaining    = remaining_reg;
            cand_next.exec         = exec_reg;
        end
        else
        begin
            cand_next = cand_in;
        end
    end

    always_ff @(posedge clk)
    begin
        exec_reg      <= exec_next;
        period_reg    <= period_next;
        release_reg   <= release_next;
        deadline_reg  <= deadline_next;
        remaining_reg <= remaining_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;

endmodule

// File: hdl/edf_periodic_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler
// preemptive earliest-deadline-first scheduler for periodic tasks
// ----------------------------------------------------------------------------
// Every item gives one result. A load item writes one task slot and returns
// the counters. A tick item passes through the SCAN, CALC, DIFF and OUT
// states before its result, and the block takes no new item until it is
// back in IDLE; OUT waits while the output register is still full. The scan
// runs along the chain of task cells: the best candidate moves one cell per
// cycle, so the earliest eligible deadline has reached the last cell when
// SCAN ends; CALC, DIFF and OUT then work out the waiting and turnaround
// terms and write back the picked task. A finished result sits in an output
// register, and the block takes the next item while it waits there. The user
// must write task_count only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler
    import edfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // task_count register
    input  logic        task_count_we,
    input  logic [4:0]  task_count_wdata,
    // item channel
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_DIFF,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic [4:0]        task_count_reg;
    item_t             item_reg;
    cand_t             pick_reg;

    // running counters
    logic [31:0] time_now_reg;
    logic [31:0] busy_count_reg;
    logic [47:0] wait_total_reg;
    logic [47:0] turn_total_reg;

    // tick arithmetic, one step per state
    logic [31:0]        time_new_reg;
    logic signed [32:0] turn_reg;
    logic [15:0]        rem_after_reg;
    logic               done_reg;
    logic [31:0]        turn_pos_reg;
    logic [31:0]        wait_pos_reg;

    result_t result_reg;
    logic    result_valid_reg;

    // next values of the counters and the result at the write-back cycle
    logic [31:0] time_next;
    logic [31:0] busy_next;
    logic [47:0] wait_next;
    logic [47:0] turn_next;
    logic [48:0] wait_sum;
    logic [48:0] turn_sum;
    result_t     result_next;

    logic               out_free;
    logic               write_back;
    logic               load_ok;
    logic signed [33:0] wait_full;
    cell_cmd_t          cell_cmd;

    logic [MAX_TASKS-1:0] active;
    cand_t                cand_chain [MAX_TASKS+1];

    // ------------------------------------------------------------------------
    // cell chain: cell 0 sees an empty candidate, the last one gives the pick
    // ------------------------------------------------------------------------
    assign cand_chain[0] = '0;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        // slots at or above task_count take no part in the scan
        assign active[i] = (int'(task_count_reg) > i);

        edfs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot     (IDX_W'(i)),
            .active   (active[i]),
            .time_now (time_now_reg),
            .cmd      (cell_cmd),
            .cand_in  (cand_chain[i]),
            .cand_out (cand_chain[i+1])
        );
    end

    // ------------------------------------------------------------------------
    // handshake and write-back
    // ------------------------------------------------------------------------
    assign item_ready   = (state_reg == S_IDLE);
    assign out_free     = !result_valid_reg || result_ready;
    assign write_back   = (state_reg == S_OUT) && out_free;
    // loads to slots beyond the chain are dropped
    assign load_ok      = (int'(item_reg.task_index) < MAX_TASKS);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        wait_full = $signed({turn_reg[32], turn_reg}) - $signed({18'd0, pick_reg.exec});
    end

    always_comb
    begin
        cell_cmd.op           = OP_NONE;
        cell_cmd.idx          = IDX_W'(item_reg.task_index);
        cell_cmd.exec         = item_reg.exec_time;
        cell_cmd.deadline     = item_reg.first_deadline;
        cell_cmd.release_time = item_reg.first_release;
        cell_cmd.period       = item_reg.period;

        time_next = time_now_reg;
        busy_next = busy_count_reg;
        wait_next = wait_total_reg;
        turn_next = turn_total_reg;

        // 48-bit sums clamp at all ones
        wait_sum = {1'b0, wait_total_reg} + {17'd0, wait_pos_reg};
        turn_sum = {1'b0, turn_total_reg} + {17'd0, turn_pos_reg};

        result_next.ran_valid       = 1'b0;
        result_next.ran_task        = 4'd0;
        result_next.remaining_after = 16'd0;
        result_next.job_done        = 1'b0;

        if (write_back)
        begin
            if (item_reg.command == CMD_LOAD)
            begin
                if (load_ok)
                begin
                    cell_cmd.op = OP_LOAD;
                end
            end
            else
            begin
                time_next = time_new_reg;
                if (pick_reg.found)
                begin
                    cell_cmd.idx = pick_reg.idx;
                    cell_cmd.op  = done_reg ? OP_DONE : OP_DEC;
                    busy_next    = sat_add32(busy_count_reg, 32'd1);
                    result_next.ran_valid       = 1'b1;
                    result_next.ran_task        = 4'(pick_reg.idx);
                    result_next.remaining_after = rem_after_reg;
                    result_next.job_done        = done_reg;
                    if (done_reg)
                    begin
                        wait_next = wait_sum[48] ? 48'hFFFF_FFFF_FFFF : wait_sum[47:0];
                        turn_next = turn_sum[48] ? 48'hFFFF_FFFF_FFFF : turn_sum[47:0];
                    end
                end
            end
        end

        result_next.current_time   = time_next;
        result_next.busy_units     = busy_next;
        result_next.waiting_sum    = wait_next;
        result_next.turnaround_sum = turn_next;
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            scan_cnt_reg     <= '0;
            task_count_reg   <= 5'd1;
            time_now_reg     <= '0;
            busy_count_reg   <= '0;
            wait_total_reg   <= '0;
            turn_total_reg   <= '0;
            result_valid_reg <= 1'b0;
            item_reg         <= '0;
            pick_reg         <= '0;
            time_new_reg     <= '0;
            turn_reg         <= '0;
            rem_after_reg    <= '0;
            done_reg         <= 1'b0;
            turn_pos_reg     <= '0;
            wait_pos_reg     <= '0;
            result_reg       <= '0;
        end
        else
        begin
            if (task_count_we)
            begin
                task_count_reg <= task_count_wdata;
            end

            // a write-back in the same cycle refills the output register
            if (result_valid_reg && result_ready && !write_back)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg     <= item;
                        scan_cnt_reg <= '0;
                        state_reg    <= (item.command == CMD_TICK) ? S_SCAN : S_OUT;
                    end
                end
                S_SCAN:
                begin
                    // once scan_cnt_reg reaches MAX_TASKS the last cell holds the pick
                    if (scan_cnt_reg == CNT_W'(MAX_TASKS))
                    begin
                        pick_reg     <= cand_chain[MAX_TASKS];
                        time_new_reg <= sat_add32(time_now_reg, 32'd1);
                        state_reg    <= S_CALC;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                S_CALC:
                begin
                    turn_reg      <= $signed({1'b0, time_new_reg})
                                   - $signed({1'b0, pick_reg.release_time});
                    rem_after_reg <= pick_reg.remaining - 16'd1;
                    done_reg      <= pick_reg.found && (pick_reg.remaining == 16'd1);
                    state_reg     <= S_DIFF;
                end
                S_DIFF:
                begin
                    // negative or zero terms add nothing
                    turn_pos_reg <= (!turn_reg[32] && (turn_reg != '0)) ? turn_reg[31:0] : '0;
                    wait_pos_reg <= (!wait_full[33] && (wait_full != '0)) ? wait_full[31:0] : '0;
                    state_reg    <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        time_now_reg     <= time_next;
                        busy_count_reg   <= busy_next;
                        wait_total_reg   <= wait_next;
                        turn_total_reg   <= turn_next;
                        result_reg       <= result_next;
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_result_from_out : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside write-back");

    a_busy_le_time : assert property (@(posedge clk) disable iff (!rst_n)
        busy_count_reg <= time_now_reg)
        else $error("busy count ahead of time");

    a_time_monotone : assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> time_now_reg >= $past(time_now_reg))
        else $error("time went backwards");

    a_done_consistent : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.job_done)
            |-> (result_reg.ran_valid && (result_reg.remaining_after == 16'd0)))
        else $error("job done with work left");

endmodule
